FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used at the end of source_tokenizer_unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

FILE: src/stu_pkg.sv
// ----------------------------------------------------------------------------
// stu_pkg
// Widths, token kinds, character codes, the keyword matcher and the
// single-character kind map of the source tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stu_pkg;

    // field widths
    localparam int unsigned LINE_BITS     = 16;
    localparam int unsigned LENGTH_BITS   = 12;
    localparam int unsigned KEYWORD_CHARS = 9;
    localparam int unsigned KIND_W        = 6;
    localparam int unsigned CHAR_W        = 8;
    localparam int unsigned KW_AW         = $clog2(KEYWORD_CHARS);
    localparam int unsigned TOK_BITS      = 2 * LINE_BITS + LENGTH_BITS;
    localparam int unsigned DATA_W        = ((TOK_BITS + 7) / 8) * 8;

    localparam logic [LINE_BITS-1:0]   POS_MAX = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    // token kinds
    localparam logic [KIND_W-1:0] K_IDENT     = 6'd0;
    localparam logic [KIND_W-1:0] K_NUMBER    = 6'd1;
    localparam logic [KIND_W-1:0] K_STRING    = 6'd2;
    localparam logic [KIND_W-1:0] K_KW0       = 6'd3;
    localparam logic [KIND_W-1:0] K_PLUS      = 6'd14;
    localparam logic [KIND_W-1:0] K_MINUS     = 6'd15;
    localparam logic [KIND_W-1:0] K_STAR      = 6'd16;
    localparam logic [KIND_W-1:0] K_SLASH     = 6'd17;
    localparam logic [KIND_W-1:0] K_PERCENT   = 6'd18;
    localparam logic [KIND_W-1:0] K_LPAREN    = 6'd19;
    localparam logic [KIND_W-1:0] K_RPAREN    = 6'd20;
    localparam logic [KIND_W-1:0] K_LBRACE    = 6'd21;
    localparam logic [KIND_W-1:0] K_RBRACE    = 6'd22;
    localparam logic [KIND_W-1:0] K_LBRACKET  = 6'd23;
    localparam logic [KIND_W-1:0] K_RBRACKET  = 6'd24;
    localparam logic [KIND_W-1:0] K_COMMA     = 6'd25;
    localparam logic [KIND_W-1:0] K_DOT       = 6'd26;
    localparam logic [KIND_W-1:0] K_SEMI      = 6'd27;
    localparam logic [KIND_W-1:0] K_COLON     = 6'd28;
    localparam logic [KIND_W-1:0] K_EQ        = 6'd29;
    localparam logic [KIND_W-1:0] K_EQEQ      = 6'd30;
    localparam logic [KIND_W-1:0] K_BANGEQ    = 6'd31;
    localparam logic [KIND_W-1:0] K_LESS      = 6'd32;
    localparam logic [KIND_W-1:0] K_LESSEQ    = 6'd33;
    localparam logic [KIND_W-1:0] K_GREATER   = 6'd34;
    localparam logic [KIND_W-1:0] K_GREATEREQ = 6'd35;
    localparam logic [KIND_W-1:0] K_UNKNOWN   = 6'd36;
    localparam logic [KIND_W-1:0] K_END       = 6'd37;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;

    // keyword table, first character in the top byte
    localparam int unsigned KW_COUNT = 11;
    localparam int unsigned KW_MAX   = 9;
    localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
        {"func", 40'h0}, {"return", 24'h0}, {"var", 48'h0}, {"if", 56'h0},
        {"else", 40'h0}, {"while", 32'h0}, {"struct", 24'h0}, "interface",
        {"true", 40'h0}, {"false", 32'h0}, {"new", 48'h0}
    };
    localparam int unsigned KW_LEN [KW_COUNT] = '{4, 6, 3, 2, 4, 5, 6, 9, 4, 5, 3};

    typedef logic [KEYWORD_CHARS-1:0][CHAR_W-1:0] t_kwbuf;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [LINE_BITS-1:0]   line;
        logic [LINE_BITS-1:0]   col;
        logic [LENGTH_BITS-1:0] len;
        logic                   last;
    } t_token;

    // Map a finished word to its keyword kind, or to identifier
    function automatic logic [KIND_W-1:0] kw_kind(input t_kwbuf kw_buf,
                                                  input logic [LENGTH_BITS-1:0] wlen);
        logic [KIND_W-1:0] kind;
        logic              hit;
        kind = K_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit = (wlen == LENGTH_BITS'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX; i++) begin
                if (i < KW_LEN[k] && kw_buf[i] != KW_TEXT[k][8*KW_MAX-1-8*i -: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit && kind == K_IDENT) begin
                kind = K_KW0 + KIND_W'(k);
            end
        end
        return kind;
    endfunction

    // Kind of a byte that forms a one-character token by itself
    function automatic logic [KIND_W-1:0] single_kind(input logic [CHAR_W-1:0] ch);
        logic [KIND_W-1:0] kind;
        case (ch)
            "+":     kind = K_PLUS;
            "-":     kind = K_MINUS;
            "*":     kind = K_STAR;
            "%":     kind = K_PERCENT;
            "(":     kind = K_LPAREN;
            ")":     kind = K_RPAREN;
            "{":     kind = K_LBRACE;
            "}":     kind = K_RBRACE;
            "[":     kind = K_LBRACKET;
            "]":     kind = K_RBRACKET;
            ",":     kind = K_COMMA;
            ".":     kind = K_DOT;
            ";":     kind = K_SEMI;
            ":":     kind = K_COLON;
            default: kind = K_UNKNOWN;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

FILE: src/source_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// source_tokenizer_unit
// Streaming lexer: one source byte per beat in, tokens with start position
// and length out.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | tdata                           | tuser      | tlast
//  --------+-----+---------------------------------+------------+-------------
//  s       | in  | char_code                       | -          | end_of_source
//  m       | out | start_line, start_column, len   | token_kind | last_of_run
//
//  A byte is scanned in the cycle it is accepted and its tokens (0 to 3) land
//  in a three-entry result buffer. While the output is ready one token leaves
//  per cycle, so a byte causing several tokens holds the input while they drain
//  and a byte causing at most one token flows at one per cycle. The input takes
//  a beat whenever the buffer will be empty at the edge, so output stalls back
//  up to the input. Synchronous active-low reset returns the scanner to line 1,
//  column 1.
`default_nettype none

module source_tokenizer_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [7:0]                  i_s_tdata,   // [7:0] char_code
    input  wire logic                        i_s_tlast,   // end_of_source
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // [15:0] start_line, [31:16] start_column, [43:32] token_length, rest zero
    output logic [stu_pkg::DATA_W-1:0]       o_m_tdata,
    output logic [stu_pkg::KIND_W-1:0]       o_m_tuser,   // [5:0] token_kind
    output logic                             o_m_tlast    // last_of_run
);

    // scanner modes
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_IDENT   = 4'd1;
    localparam logic [3:0] M_NUMBER  = 4'd2;
    localparam logic [3:0] M_STRING  = 4'd3;
    localparam logic [3:0] M_SLASH   = 4'd4;
    localparam logic [3:0] M_COMMENT = 4'd5;
    localparam logic [3:0] M_EQ      = 4'd6;
    localparam logic [3:0] M_BANG    = 4'd7;
    localparam logic [3:0] M_LESS    = 4'd8;
    localparam logic [3:0] M_GREATER = 4'd9;

    localparam int unsigned LB = stu_pkg::LINE_BITS;
    localparam int unsigned NB = stu_pkg::LENGTH_BITS;

    // scanner state
    logic [3:0]       r_mode, n_mode;
    logic [LB-1:0]    r_line, n_line;
    logic [LB-1:0]    r_col, n_col;
    logic [LB-1:0]    r_sline, n_sline;
    logic [LB-1:0]    r_scol, n_scol;
    logic [NB-1:0]    r_plen, n_plen;
    stu_pkg::t_kwbuf  r_kwbuf;

    // result buffer
    stu_pkg::t_token  r_q [3];
    logic [1:0]       r_qn;

    // scan intermediates
    logic [3:0]       f_mode;
    logic [LB-1:0]    f_line, f_col, f_sline, f_scol;
    logic [NB-1:0]    f_plen;
    stu_pkg::t_kwbuf  f_kwbuf, wk_buf;
    logic [NB-1:0]    wk_len;
    logic [stu_pkg::KIND_W-1:0] word_kind;
    logic             kw_we;
    logic [stu_pkg::KW_AW-1:0]  kw_addr;
    logic             start_go, adv, a_word, flush_go;
    stu_pkg::t_token  cand [4];
    logic [3:0]       cand_v;
    stu_pkg::t_token  slot [3];
    logic [1:0]       slot_n;

    logic [7:0]       ch;
    logic             ch_zero, is_space, is_digit, is_alpha, is_word;
    logic             s_fire, m_fire;

    assign ch       = i_s_tdata;
    assign ch_zero  = (ch == stu_pkg::CH_NUL);
    assign is_space = (ch == stu_pkg::CH_SPACE) || (ch >= stu_pkg::CH_TAB && ch <= stu_pkg::CH_CR);
    assign is_digit = (ch >= "0" && ch <= "9");
    assign is_alpha = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    assign is_word  = is_alpha || is_digit || (ch == stu_pkg::CH_UNDER);

    assign o_s_tready = (r_qn == 2'd0) || (r_qn == 2'd1 && i_m_tready);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign m_fire     = o_m_tvalid && i_m_tready;

    function automatic logic [stu_pkg::KIND_W-1:0] one_kind(input logic [3:0] mode);
        logic [stu_pkg::KIND_W-1:0] kind;
        case (mode)
            M_SLASH:   kind = stu_pkg::K_SLASH;
            M_EQ:      kind = stu_pkg::K_EQ;
            M_LESS:    kind = stu_pkg::K_LESS;
            M_GREATER: kind = stu_pkg::K_GREATER;
            default:   kind = stu_pkg::K_UNKNOWN;
        endcase
        return kind;
    endfunction

    function automatic logic [stu_pkg::KIND_W-1:0] two_kind(input logic [3:0] mode);
        logic [stu_pkg::KIND_W-1:0] kind;
        case (mode)
            M_EQ:      kind = stu_pkg::K_EQEQ;
            M_LESS:    kind = stu_pkg::K_LESSEQ;
            M_GREATER: kind = stu_pkg::K_GREATEREQ;
            default:   kind = stu_pkg::K_BANGEQ;
        endcase
        return kind;
    endfunction

    // Scan one byte: close the pending token, open the next, move the position
    always_comb begin
        f_mode   = r_mode;
        f_line   = r_line;
        f_col    = r_col;
        f_sline  = r_sline;
        f_scol   = r_scol;
        f_plen   = r_plen;
        kw_we    = 1'b0;
        kw_addr  = r_plen[stu_pkg::KW_AW-1:0];
        start_go = 1'b0;
        adv      = 1'b0;
        a_word   = 1'b0;
        cand_v   = '0;
        for (int i = 0; i < 4; i++) begin
            cand[i] = '0;
        end
        cand[0].line = r_sline;
        cand[0].col  = r_scol;

        if (!ch_zero) begin
            case (r_mode)
                M_IDLE: begin
                    start_go = 1'b1;
                end
                M_IDENT: begin
                    if (is_word) begin
                        kw_we  = (r_plen < NB'(stu_pkg::KEYWORD_CHARS));
                        f_plen = (r_plen == stu_pkg::LEN_MAX) ? r_plen : r_plen + 1'b1;
                        adv    = 1'b1;
                    end else begin
                        cand_v[0]   = 1'b1;
                        a_word      = 1'b1;
                        cand[0].len = r_plen;
                        start_go    = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit) begin
                        f_plen = (r_plen == stu_pkg::LEN_MAX) ? r_plen : r_plen + 1'b1;
                        adv    = 1'b1;
                    end else begin
                        cand_v[0]    = 1'b1;
                        cand[0].kind = stu_pkg::K_NUMBER;
                        cand[0].len  = r_plen;
                        start_go     = 1'b1;
                    end
                end
                M_STRING: begin
                    if (ch == stu_pkg::CH_QUOTE) begin
                        cand_v[0]    = 1'b1;
                        cand[0].kind = stu_pkg::K_STRING;
                        cand[0].len  = r_plen;
                        f_mode       = M_IDLE;
                    end else begin
                        f_plen = (r_plen == stu_pkg::LEN_MAX) ? r_plen : r_plen + 1'b1;
                    end
                    adv = 1'b1;
                end
                M_SLASH: begin
                    if (ch == stu_pkg::CH_SLASH) begin
                        f_mode = M_COMMENT;
                        adv    = 1'b1;
                    end else begin
                        cand_v[0]    = 1'b1;
                        cand[0].kind = stu_pkg::K_SLASH;
                        cand[0].len  = NB'(1);
                        start_go     = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (ch == stu_pkg::CH_NL) begin
                        f_mode = M_IDLE;
                    end
                    adv = 1'b1;
                end
                M_EQ, M_BANG, M_LESS, M_GREATER: begin
                    cand_v[0] = 1'b1;
                    if (ch == stu_pkg::CH_EQ) begin
                        cand[0].kind = two_kind(r_mode);
                        cand[0].len  = NB'(2);
                        f_mode       = M_IDLE;
                        adv          = 1'b1;
                    end else begin
                        cand[0].kind = one_kind(r_mode);
                        cand[0].len  = NB'(1);
                        start_go     = 1'b1;
                    end
                end
                default: begin
                    start_go = 1'b1;
                end
            endcase

            // open a new token at the current position
            if (start_go) begin
                f_sline = r_line;
                f_scol  = r_col;
                f_plen  = '0;
                f_mode  = M_IDLE;
                adv     = 1'b1;
                if (is_space) begin
                    f_mode = M_IDLE;
                end else if (is_digit) begin
                    f_mode = M_NUMBER;
                    f_plen = NB'(1);
                end else if (is_alpha || ch == stu_pkg::CH_UNDER) begin
                    f_mode  = M_IDENT;
                    f_plen  = NB'(1);
                    kw_we   = 1'b1;
                    kw_addr = '0;
                end else if (ch == stu_pkg::CH_QUOTE) begin
                    f_mode = M_STRING;
                end else if (ch == stu_pkg::CH_SLASH) begin
                    f_mode = M_SLASH;
                end else if (ch == stu_pkg::CH_EQ) begin
                    f_mode = M_EQ;
                end else if (ch == stu_pkg::CH_BANG) begin
                    f_mode = M_BANG;
                end else if (ch == stu_pkg::CH_LT) begin
                    f_mode = M_LESS;
                end else if (ch == stu_pkg::CH_GT) begin
                    f_mode = M_GREATER;
                end else begin
                    cand_v[1]    = 1'b1;
                    cand[1].kind = stu_pkg::single_kind(ch);
                    cand[1].line = r_line;
                    cand[1].col  = r_col;
                    cand[1].len  = NB'(1);
                end
            end

            // advance line and column, saturating
            if (adv) begin
                if (ch == stu_pkg::CH_NL) begin
                    f_line = (r_line == stu_pkg::POS_MAX) ? r_line : r_line + 1'b1;
                    f_col  = LB'(1);
                end else begin
                    f_col  = (r_col == stu_pkg::POS_MAX) ? r_col : r_col + 1'b1;
                end
            end
        end

        // keyword match on the word being closed
        f_kwbuf = r_kwbuf;
        if (kw_we) begin
            f_kwbuf[kw_addr] = ch;
        end
        wk_buf    = (f_mode == M_IDENT) ? f_kwbuf : r_kwbuf;
        wk_len    = (f_mode == M_IDENT) ? f_plen : r_plen;
        word_kind = stu_pkg::kw_kind(wk_buf, wk_len);
        if (a_word) begin
            cand[0].kind = word_kind;
        end

        // flush the pending token and append the end token
        flush_go     = ch_zero || i_s_tlast;
        cand[2].line = f_sline;
        cand[2].col  = f_scol;
        cand[2].len  = f_plen;
        cand[3].kind = stu_pkg::K_END;
        cand[3].line = f_line;
        cand[3].col  = f_col;
        if (flush_go) begin
            cand_v[3] = 1'b1;
            case (f_mode)
                M_IDENT: begin
                    cand_v[2]    = 1'b1;
                    cand[2].kind = word_kind;
                end
                M_NUMBER: begin
                    cand_v[2]    = 1'b1;
                    cand[2].kind = stu_pkg::K_NUMBER;
                end
                M_STRING: begin
                    cand_v[2]    = 1'b1;
                    cand[2].kind = stu_pkg::K_STRING;
                end
                M_SLASH, M_EQ, M_BANG, M_LESS, M_GREATER: begin
                    cand_v[2]    = 1'b1;
                    cand[2].kind = one_kind(f_mode);
                    cand[2].len  = NB'(1);
                end
                default: begin
                    cand_v[2] = 1'b0;
                end
            endcase
        end

        // next state: back to reset values after the end token
        if (flush_go) begin
            n_mode  = M_IDLE;
            n_line  = LB'(1);
            n_col   = LB'(1);
            n_sline = LB'(1);
            n_scol  = LB'(1);
            n_plen  = '0;
        end else begin
            n_mode  = f_mode;
            n_line  = f_line;
            n_col   = f_col;
            n_sline = f_sline;
            n_scol  = f_scol;
            n_plen  = f_plen;
        end

        // pack emitted tokens in order and mark the last one
        for (int j = 0; j < 3; j++) begin
            slot[j] = '0;
        end
        slot_n = '0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && slot_n != 2'd3) begin
                slot[slot_n] = cand[i];
                slot_n       = slot_n + 2'd1;
            end
        end
        if (slot_n != 2'd0) begin
            slot[slot_n - 2'd1].last = 1'b1;
        end
    end

    // Hold scanner state; advance on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_line  <= LB'(1);
            r_col   <= LB'(1);
            r_sline <= LB'(1);
            r_scol  <= LB'(1);
            r_plen  <= '0;
        end else if (s_fire) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_plen  <= n_plen;
        end
    end

    // Write the keyword buffer entry for the current word
    always_ff @(posedge i_clk) begin
        if (s_fire && kw_we) begin
            r_kwbuf[kw_addr] <= ch;
        end
    end

    // Load the result buffer on a beat, else drop the head on each output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qn <= '0;
        end else if (s_fire) begin
            r_qn <= slot_n;
        end else if (m_fire) begin
            r_qn <= r_qn - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_q[0] <= slot[0];
            r_q[1] <= slot[1];
            r_q[2] <= slot[2];
        end else if (m_fire) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

    // Drive the output beat from the buffer head
    assign o_m_tvalid = (r_qn != 2'd0);
    assign o_m_tdata  = stu_pkg::DATA_W'({r_q[0].len, r_q[0].col, r_q[0].line});
    assign o_m_tuser  = r_q[0].kind;
    assign o_m_tlast  = r_q[0].last;

`include "assert_macros.svh"

    // a single queued token is always the last one of its byte
    `ASSERT_IMPLY(a_single_is_last, i_clk, i_rst_n, r_qn == 2'd1, r_q[0].last)
    // with more tokens queued the head is never the last
    `ASSERT_IMPLY(a_multi_not_last, i_clk, i_rst_n, r_qn > 2'd1, !r_q[0].last)
    // input is taken only when the buffer drains this cycle
    `ASSERT_IMPLY(a_ready_drained, i_clk, i_rst_n, o_s_tready,
                  r_qn == 2'd0 || (r_qn == 2'd1 && i_m_tready))
    // a zero byte leaves the scanner at the start of a fresh source
    `ASSERT_NEXT(a_zero_resets, i_clk, i_rst_n, s_fire && ch_zero,
                 r_mode == M_IDLE && r_line == LB'(1) && r_col == LB'(1) && r_plen == '0)

endmodule

`default_nettype wire
